// File: rtl/lpht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared sizes, payload structs, result codes and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

	// Table geometry. TABLE_SLOTS must be a power of two: the home slot is
	// taken from the low hash bits and the probe index wraps naturally.
	localparam int TABLE_SLOTS = 16;
	localparam int KEY_BYTES   = 8;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);
	localparam int KEY_W       = 8 * KEY_BYTES;
	localparam int LEN_W       = 4;
	localparam int VALUE_W     = 32;
	localparam int HASH_W      = 64;
	localparam int HALF_W      = HASH_W / 2;
	localparam int HASH_SHIFT  = 15;
	localparam logic [HALF_W-1:0] HASH_MUL = 32'h5bd1_e995;

	// Result codes.
	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_UPDATED   = 3'd3,
		ST_FULL      = 3'd4
	} status_code_t;

	// Operation codes of the input item.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Input item.
	typedef struct packed {
		logic                      cmd;
		logic [63:0]               key_bytes;
		logic [3:0]                key_len;
		logic signed [31:0]        write_value;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [2:0]                status;
		logic signed [31:0]        read_value;
		logic [4:0]                entry_count;
	} out_item_t;

	// One stored slot.
	typedef struct packed {
		logic [KEY_W-1:0]          key;
		logic [LEN_W-1:0]          len;
		logic [VALUE_W-1:0]        value;
	} slot_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                      load_in;
		logic                      mul_lo;
		logic                      mul_hi;
		logic                      set_home;
		logic                      mem_rd;
		logic                      step;
		logic                      wr_entry;
		logic                      wr_new;
		logic                      set_result;
		logic                      res_from_mem;
		status_code_t              res_code;
		logic                      load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic                      rounds_zero;
		logic                      is_insert;
		logic                      table_full;
		logic                      occupied;
		logic                      match;
		logic                      probes_last;
	} dp_sts_t;

	// Mask that keeps the first len bytes of a key.
	function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (LEN_W'(i) < len) begin
				m[8*i +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// File: rtl/linear_probe_hash_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressed key/value table of 16 slots with linear probing, taking
// lookups and inserts of keys of up to 8 bytes.
// ----------------------------------------------------------------------------
//  Channel | Handshake               | Payload
//  in      | in_valid / in_ready     | in_item  (cmd, key, length, value)
//  out     | out_valid / out_ready   | out_item (status, value, count)
//
// The time an item takes grows with L, the used key bytes (0..8), and with
// P, the slots probed (0..16, zero when a full table turns an insert away);
// the shared hash multiplier and the single read port of the slot memory
// make it so. One item is in work at a time, and a result that is not taken
// holds the next one back. A finished result waits in the output register
// while the next item is taken in. Reset clears the occupied bits and the
// count at once, so the table is usable as soon as reset is released.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top
	import lpht_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer.
	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hash unit, slot store and result registers.
	lpht_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.out_item (out_item)
	);

endmodule
`default_nettype wire

// File: rtl/lpht_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences one item through the hash rounds and the slot probes, picks the
// result code and owns the input ready flag and the output valid flag.
// ----------------------------------------------------------------------------
module lpht_ctrl
	import lpht_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROUND,
		S_MUL_LO,
		S_MUL_HI,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		cmd      = '0;
		cmd.res_code = ST_NOT_FOUND;
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_ROUND;
				end
			end
			S_ROUND: begin
				if (sts.rounds_zero) begin
					if (sts.is_insert && sts.table_full) begin
						cmd.set_result = 1'b1;
						cmd.res_code   = ST_FULL;
						state_d        = S_FINISH;
					end else begin
						cmd.set_home = 1'b1;
						state_d      = S_PROBE_RD;
					end
				end else begin
					state_d = S_MUL_LO;
				end
			end
			S_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MUL_HI;
			end
			S_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_ROUND;
			end
			S_PROBE_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_PROBE_CHK;
			end
			S_PROBE_CHK: begin
				if (!sts.occupied) begin
					// An empty slot ends the probe: an insert places its new entry here.
					cmd.set_result = 1'b1;
					state_d        = S_FINISH;
					if (sts.is_insert) begin
						cmd.wr_entry = 1'b1;
						cmd.wr_new   = 1'b1;
						cmd.res_code = ST_INSERTED;
					end else begin
						cmd.res_code = ST_NOT_FOUND;
					end
				end else if (sts.match) begin
					cmd.set_result = 1'b1;
					state_d        = S_FINISH;
					if (sts.is_insert) begin
						cmd.wr_entry = 1'b1;
						cmd.res_code = ST_UPDATED;
					end else begin
						cmd.res_from_mem = 1'b1;
						cmd.res_code     = ST_FOUND;
					end
				end else begin
					cmd.step = 1'b1;
					if (sts.probes_last) begin
						cmd.set_result = 1'b1;
						cmd.res_code   = sts.is_insert ? ST_FULL : ST_NOT_FOUND;
						state_d        = S_FINISH;
					end else begin
						state_d = S_PROBE_RD;
					end
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/lpht_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Holds the current item, the hash unit with one shared 32x32 multiplier,
// the slot memory with its occupied bits, the entry count and the output
// register.
// ----------------------------------------------------------------------------
module lpht_dp
	import lpht_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t in_item,
	input  wire dp_cmd_t  cmd,
	output dp_sts_t       sts,
	output out_item_t     out_item
);

	// Item registers.
	logic                 op_q;
	logic [KEY_W-1:0]     key_q;
	logic [LEN_W-1:0]     len_q;
	logic [VALUE_W-1:0]   wval_q;

	// Hash unit registers.
	logic [HASH_W-1:0]    hash_q;
	logic [KEY_W-1:0]     hkey_q;
	logic [LEN_W-1:0]     rounds_q;
	logic [HASH_W-1:0]    prod_q;

	// Probe registers.
	logic [SLOT_W-1:0]    slot_q;
	logic [SLOT_W-1:0]    probes_q;

	// Slot store.
	slot_entry_t          mem_q [TABLE_SLOTS];
	slot_entry_t          rd_q;
	logic [TABLE_SLOTS-1:0] occ_q;
	logic [COUNT_W-1:0]   count_q;

	// Result registers.
	logic [2:0]           res_status_q;
	logic [VALUE_W-1:0]   res_value_q;
	out_item_t            out_q;

	logic [LEN_W-1:0]     len_sat;
	logic [HASH_W-1:0]    hash_x;
	logic [HALF_W-1:0]    mul_a;
	logic [HASH_W-1:0]    mul_p;
	logic [HASH_W-1:0]    mix_sum;

	// Saturate the key length to the key width.
	assign len_sat = (in_item.key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
		: in_item.key_len;

	// Shared multiplier: the low half of the hash is multiplied first, the
	// high half's low product is then folded into the upper word.
	assign hash_x  = hash_q ^ {{(HASH_W-8){1'b0}}, hkey_q[7:0]};
	assign mul_a   = cmd.mul_hi ? hash_x[HASH_W-1:HALF_W] : hash_x[HALF_W-1:0];
	assign mul_p   = HASH_W'(mul_a) * HASH_W'(HASH_MUL);
	assign mix_sum = {prod_q[HASH_W-1:HALF_W] + mul_p[HALF_W-1:0],
		prod_q[HALF_W-1:0]};

	// Item capture and hash rounds.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= in_item.cmd;
			key_q    <= in_item.key_bytes & byte_mask(len_sat);
			hkey_q   <= in_item.key_bytes;
			len_q    <= len_sat;
			wval_q   <= in_item.write_value;
			rounds_q <= len_sat;
			hash_q   <= '0;
		end
		if (cmd.mul_lo) begin
			prod_q <= mul_p;
		end
		if (cmd.mul_hi) begin
			hash_q   <= mix_sum ^ (mix_sum >> HASH_SHIFT);
			hkey_q   <= hkey_q >> 8;
			rounds_q <= rounds_q - 1'b1;
		end
	end

	// Probe position.
	always_ff @(posedge clk) begin
		if (cmd.set_home) begin
			slot_q   <= hash_q[SLOT_W-1:0];
			probes_q <= '0;
		end else if (cmd.step) begin
			slot_q   <= slot_q + 1'b1;
			probes_q <= probes_q + 1'b1;
		end
	end

	// Slot memory with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_entry) begin
			mem_q[slot_q] <= '{key: key_q, len: len_q, value: wval_q};
		end
		if (cmd.mem_rd) begin
			rd_q <= mem_q[slot_q];
		end
	end

	// Occupied bits and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			count_q <= '0;
		end else if (cmd.wr_new) begin
			occ_q[slot_q] <= 1'b1;
			count_q       <= count_q + 1'b1;
		end
	end

	// Result and output registers.
	always_ff @(posedge clk) begin
		if (cmd.set_result) begin
			res_status_q <= cmd.res_code;
			res_value_q  <= cmd.res_from_mem ? rd_q.value : '0;
		end
		if (cmd.load_out) begin
			out_q.status      <= res_status_q;
			out_q.read_value  <= res_value_q;
			out_q.entry_count <= 5'(count_q);
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.rounds_zero = (rounds_q == '0);
		sts.is_insert   = (op_q == OP_INSERT);
		sts.table_full  = (count_q >= COUNT_W'(TABLE_SLOTS));
		sts.occupied    = occ_q[slot_q];
		sts.match       = occ_q[slot_q] && (rd_q.key == key_q) && (rd_q.len == len_q);
		sts.probes_last = (probes_q == SLOT_W'(TABLE_SLOTS - 1));
	end

	assign out_item = out_q;

endmodule
`default_nettype wire

// File: rtl/lpht_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Linear probe hash table checker
// Port-level assertions on the result channel and the item flow, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module lpht_checker
	import lpht_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_item
);

	// A result that is not taken holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed before its transfer");

	// The count never passes the slot count.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.entry_count <= 5'(TABLE_SLOTS))
		else $error("entry count above slot count");

	// Only a successful lookup returns a value.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_FOUND |-> out_item.read_value == '0)
		else $error("nonzero value without a hit");

	// A full report only comes with every slot taken.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_FULL
			|-> out_item.entry_count == 5'(TABLE_SLOTS))
		else $error("table full reported with free slots");

	// An input transfer starts work that keeps the input closed while the item is in work.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

endmodule

bind linear_probe_hash_table_top lpht_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Linear probe hash table regression bench
// Drives lookups and inserts through the valid/ready input channel and
// checks every result against a behavioral copy of the table that is kept
// in step with each accepted transfer. A directed pass covers empty and
// overlong keys, keys made of zero bytes, and the value extremes. A random
// pass then grows the table one key at a time between bursts of lookups and
// updates, and a last pass works on the full table. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb;
	import lpht_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	// Longest item: eight hash rounds and sixteen probes.
	localparam int DRAIN_CYCLES = 64;
	localparam int OPS_PER_NEW_KEY = 90;
	localparam int FULL_TABLE_ITEMS = 900;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// Behavioral copy of the slot store.
	logic [KEY_W-1:0]          tbl_key   [TABLE_SLOTS];
	logic [LEN_W-1:0]          tbl_len   [TABLE_SLOTS];
	logic signed [VALUE_W-1:0] tbl_value [TABLE_SLOTS];
	bit                        tbl_used  [TABLE_SLOTS];
	int                        used_count = 0;

	out_item_t pending_results[$];
	out_item_t want;
	int        error_count = 0;
	int        result_index = 0;
	int        cycle_count = 0;
	int        stall_left = 0;
	logic      calm = 1'b0;

	linear_probe_hash_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Free-running clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Cycle counter, calm stretches and the run timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 256 == 255) begin
			calm <= ($urandom_range(0, 3) == 0);
		end
		if (cycle_count == LIMIT_CYCLES) begin
			$display("linear_probe_hash_table_top regression: fail");
			$finish;
		end
	end

	// Result-side back pressure: mostly short stalls, a few long ones.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (calm || $urandom_range(0, 99) < 55) begin
			out_ready <= 1'b1;
		end else begin
			out_ready  <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
			                                          : $urandom_range(0, 3);
		end
	end

	task automatic report_mismatch(input string what);
		$display("cycle %0d result %0d: %s", cycle_count, result_index, what);
		error_count++;
	endtask

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (out_item.status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %0d",
						out_item.status, want.status));
				end
				if (out_item.read_value !== want.read_value) begin
					report_mismatch($sformatf("read_value %0d, expected %0d",
						out_item.read_value, want.read_value));
				end
				if (out_item.entry_count !== want.entry_count) begin
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						out_item.entry_count, want.entry_count));
				end
			end
			result_index++;
		end
	end

	// Mask keeping the first len bytes of a key.
	function automatic logic [KEY_W-1:0] keep_mask(input logic [LEN_W-1:0] len);
		if (len >= KEY_BYTES) begin
			return '1;
		end
		return (64'd1 << (8 * len)) - 64'd1;
	endfunction

	// Byte-serial 64-bit multiply/xor-shift hash.
	function automatic logic [HASH_W-1:0] mix_key(input logic [KEY_W-1:0] key,
	                                              input logic [LEN_W-1:0] len);
		logic [HASH_W-1:0] h;
		h = '0;
		for (int i = 0; i < len; i++) begin
			h ^= {56'd0, key[8*i +: 8]};
			h = h * 64'h0000_0000_5bd1_e995;
			h ^= h >> HASH_SHIFT;
		end
		return h;
	endfunction

	// Apply one accepted item to the table copy and return its result.
	function automatic out_item_t apply_to_table(input in_item_t item);
		logic [LEN_W-1:0]  len;
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] h;
		logic [SLOT_W-1:0] s;
		out_item_t         r;
		bit                done;
		len = (item.key_len > KEY_BYTES) ? LEN_W'(KEY_BYTES) : item.key_len;
		key = item.key_bytes & keep_mask(len);
		h = mix_key(key, len);
		s = SLOT_W'(h % 64'(TABLE_SLOTS));
		r.status = ST_NOT_FOUND;
		r.read_value = '0;
		done = 1'b0;
		if (item.cmd == OP_LOOKUP) begin
			for (int p = 0; p < TABLE_SLOTS && !done; p++) begin
				if (!tbl_used[s]) begin
					done = 1'b1;
				end else if (tbl_len[s] == len && tbl_key[s] == key) begin
					r.status = ST_FOUND;
					r.read_value = tbl_value[s];
					done = 1'b1;
				end else begin
					s = s + 1'b1;
				end
			end
		end else if (used_count >= TABLE_SLOTS) begin
			r.status = ST_FULL;
		end else begin
			r.status = ST_FULL;
			for (int p = 0; p < TABLE_SLOTS && !done; p++) begin
				if (!tbl_used[s]) begin
					tbl_used[s] = 1'b1;
					tbl_key[s] = key;
					tbl_len[s] = len;
					tbl_value[s] = item.write_value;
					used_count++;
					r.status = ST_INSERTED;
					done = 1'b1;
				end else if (tbl_len[s] == len && tbl_key[s] == key) begin
					tbl_value[s] = item.write_value;
					r.status = ST_UPDATED;
					done = 1'b1;
				end else begin
					s = s + 1'b1;
				end
			end
		end
		r.entry_count = 5'(used_count);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic in_item_t make_item(input logic cmd, input logic [63:0] key,
	                                       input logic [3:0] len,
	                                       input logic signed [31:0] value);
		in_item_t item;
		item.cmd = cmd;
		item.key_bytes = key;
		item.key_len = len;
		item.write_value = value;
		return item;
	endfunction

	// Random key, mostly of legal length, sometimes overlong.
	function automatic in_item_t random_key_item(input logic cmd);
		logic [3:0] len;
		len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
		                                  : 4'($urandom_range(0, 8));
		return make_item(cmd, {$urandom, $urandom}, len, $urandom);
	endfunction

	// A key already in the table, with random bytes past its length.
	function automatic in_item_t stored_key_item(input logic cmd);
		int         i;
		logic [3:0] len;
		logic [63:0] key;
		if (used_count == 0) begin
			return random_key_item(cmd);
		end
		do begin
			i = $urandom_range(0, TABLE_SLOTS - 1);
		end while (!tbl_used[i]);
		len = tbl_len[i];
		key = tbl_key[i] | ({$urandom, $urandom} & ~keep_mask(len));
		if (len == KEY_BYTES && $urandom_range(0, 3) == 0) begin
			len = 4'($urandom_range(9, 15));
		end
		return make_item(cmd, key, len, $urandom);
	endfunction

	// A stored key with one used bit flipped or its length moved by one.
	function automatic in_item_t near_miss_item(input logic cmd);
		in_item_t item;
		item = stored_key_item(cmd);
		if (item.key_len > KEY_BYTES) begin
			item.key_len = LEN_W'(KEY_BYTES);
		end
		if (item.key_len != 0 && $urandom_range(0, 1) == 0) begin
			item.key_bytes[$urandom_range(0, 8 * item.key_len - 1)] ^= 1'b1;
		end else if (item.key_len == 0 || $urandom_range(0, 1) == 0) begin
			item.key_len = (item.key_len == KEY_BYTES) ? item.key_len - 1'b1
			                                           : item.key_len + 1'b1;
		end else begin
			item.key_len = item.key_len - 1'b1;
		end
		return item;
	endfunction

	// Offer one item and wait for its transfer; in_valid stays high when the
	// next item follows without a gap.
	task automatic send_item(input in_item_t item);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= item;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(apply_to_table(item));
	endtask

	// Empty table, empty and overlong keys, zero-byte keys, value extremes.
	task automatic test_directed();
		send_item(make_item(OP_LOOKUP, 64'h0, 4'd0, 32'sd0));
		send_item(make_item(OP_LOOKUP, 64'h0123_4567_89ab_cdef, 4'd8, -32'sd1));
		send_item(make_item(OP_INSERT, 64'h0, 4'd0, 32'sh7fff_ffff));
		send_item(make_item(OP_LOOKUP, '1, 4'd0, 32'sd0));
		send_item(make_item(OP_INSERT, '1, 4'd15, 32'sh8000_0000));
		send_item(make_item(OP_LOOKUP, '1, 4'd8, 32'sd0));
		send_item(make_item(OP_LOOKUP, '1, 4'd9, 32'sd0));
		send_item(make_item(OP_LOOKUP, '1, 4'd7, 32'sd0));
		send_item(make_item(OP_INSERT, 64'h0, 4'd1, -32'sd1));
		send_item(make_item(OP_INSERT, 64'h0, 4'd2, 32'sd0));
		send_item(make_item(OP_LOOKUP, 64'h0, 4'd1, 32'sd0));
		send_item(make_item(OP_LOOKUP, 64'h0, 4'd2, 32'sd0));
		send_item(make_item(OP_LOOKUP, 64'h0, 4'd3, 32'sd0));
		// Update through a key whose ignored bytes are all ones.
		send_item(make_item(OP_INSERT, 64'hffff_ffff_ffff_ff00, 4'd1, 32'sh1234_5678));
		send_item(make_item(OP_LOOKUP, 64'h0000_0000_0000_ab00, 4'd1, 32'sd0));
		send_item(make_item(OP_INSERT, 64'h5555_5555_5555_5555, 4'd0, 32'sd0));
		send_item(make_item(OP_LOOKUP, 64'h0, 4'd0, 32'sh7fff_ffff));
		send_item(make_item(OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 4'd8, -32'sd1));
		send_item(make_item(OP_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 4'd12, 32'sd0));
		send_item(make_item(OP_LOOKUP, 64'h5555_5555_5555_5555, 4'd8, 32'sd0));
	endtask

	// Grow the table a key at a time, with lookups and updates in between.
	task automatic test_table_growth();
		int r;
		while (used_count < TABLE_SLOTS) begin
			repeat (OPS_PER_NEW_KEY) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					send_item(stored_key_item(OP_LOOKUP));
				end else if (r < 75) begin
					send_item(stored_key_item(OP_INSERT));
				end else if (r < 88) begin
					send_item(near_miss_item(OP_LOOKUP));
				end else begin
					send_item(random_key_item(OP_LOOKUP));
				end
			end
			send_item(random_key_item(OP_INSERT));
		end
	endtask

	// Full table: inserts report full, misses sweep every slot.
	task automatic test_full_table();
		int r;
		repeat (FULL_TABLE_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				send_item(stored_key_item(OP_INSERT));
			end else if (r < 45) begin
				send_item(random_key_item(OP_INSERT));
			end else if (r < 75) begin
				send_item(stored_key_item(OP_LOOKUP));
			end else if (r < 88) begin
				send_item(near_miss_item(OP_LOOKUP));
			end else begin
				send_item(random_key_item(OP_LOOKUP));
			end
		end
	endtask

	// Reset, run each test in turn, drain and report.
	initial begin
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_growth();
		test_full_table();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("linear_probe_hash_table_top regression: pass");
		end else begin
			$display("linear_probe_hash_table_top regression: fail");
		end
		$finish;
	end

endmodule

// File: linear_probe_hash_table_top.f
rtl/lpht_pkg.sv
rtl/lpht_ctrl.sv
rtl/lpht_dp.sv
rtl/linear_probe_hash_table_top.sv
rtl/lpht_checker.sv
tb/tb.sv
